>>> rtl/sfms_pkg.sv
package sfms_pkg;

  // default sizes
  localparam int unsigned         MAX_PATTERN_DEF = 32;
  localparam longint unsigned     MAX_TEXT_DEF    = 65535;

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_PATTERN = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_END     = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAT_LONG = 2'd1,
    ST_TXT_LONG = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic clr;
    logic pat_shift;
    logic txt_shift;
  } sfms_ctl_t;

endpackage

>>> rtl/substring_first_match_search.sv
// a result reaches out_* in the cycle after its end-of-text transaction
// throughput: one transaction per cycle; every text byte is compared against the
//   whole pattern in the same cycle by a row of MAX_PATTERN compare cells
// input stalls only when an end-of-text transaction meets a held, stalled result
// reset: synchronous active-low rst_n clears counters, flags and output valid;
//   stored pattern and window bytes are not reset and are masked by valid bits
module substring_first_match_search import sfms_pkg::*; #(
  parameter int unsigned     MAX_PATTERN = MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT    = MAX_TEXT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [POS_W-1:0]  in_start_pos,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_match_position,
  output logic              out_found,
  output logic [1:0]        out_status
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_TEXT + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  // search state
  logic [LEN_W-1:0] pat_len_r, pat_len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic             seen_r, seen_nxt;
  logic             err_pat_r, err_pat_nxt;
  logic             err_txt_r, err_txt_nxt;
  logic             txt_phase_r, txt_phase_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_found_r, out_found_nxt;
  status_t          out_status_r, out_status_nxt;

  logic      acc;
  req_t      req;
  sfms_ctl_t ctl;
  logic      pat_full;
  logic      txt_full;
  logic [POS_W-1:0] start_eff;
  logic      all_hit;
  logic      cand_ok;
  logic      res_ok;
  status_t   st;
  logic [CNT_W-1:0] pos_sel;

  // cell chain wiring
  logic [BYTE_W-1:0] pat_link [MAX_PATTERN+1];
  logic              vld_link [MAX_PATTERN+1];
  logic [BYTE_W-1:0] txt_link [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hits;

  // handshake
  assign req      = req_t'(in_req_type);
  assign in_stall = out_valid_r && out_stall && (req == REQ_END);
  assign acc      = in_valid && !in_stall;

  assign pat_full  = (pat_len_r == LEN_W'(MAX_PATTERN));
  assign txt_full  = (cnt_r >= CNT_W'(MAX_TEXT));
  assign start_eff = txt_phase_r ? start_r : in_start_pos;

  // cell controls
  always_comb begin
    ctl.clr       = acc && (req == REQ_END);
    ctl.pat_shift = acc && (req == REQ_PATTERN) && !txt_phase_r && !pat_full;
    ctl.txt_shift = acc && (req == REQ_TEXT) && !txt_full;
  end

  assign pat_link[0] = in_data_byte;
  assign vld_link[0] = 1'b1;
  assign txt_link[0] = in_data_byte;

  // compare cells, slot 0 holds the newest byte
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    sfms_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .pat_in      (pat_link[j]),
      .pat_vld_in  (vld_link[j]),
      .txt_in      (txt_link[j]),
      .pat_out     (pat_link[j+1]),
      .pat_vld_out (vld_link[j+1]),
      .txt_out     (txt_link[j+1]),
      .hit         (hits[j])
    );
  end

  assign all_hit = &hits;
  // candidate start (count+1 - len + 1) at or after start position
  assign cand_ok = (CMP_W'(cnt_r) + CMP_W'(2)) >= (CMP_W'(start_eff) + CMP_W'(pat_len_r));

  // search state next values
  always_comb begin
    pat_len_nxt   = pat_len_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    first_nxt     = first_r;
    seen_nxt      = seen_r;
    err_pat_nxt   = err_pat_r;
    err_txt_nxt   = err_txt_r;
    txt_phase_nxt = txt_phase_r;
    if (acc) begin
      case (req)
        REQ_PATTERN: begin
          if (!txt_phase_r) begin
            if (pat_full) begin
              err_pat_nxt = 1'b1;
            end else begin
              pat_len_nxt = pat_len_r + LEN_W'(1);
            end
          end
        end
        REQ_TEXT: begin
          if (!txt_phase_r) begin
            txt_phase_nxt = 1'b1;
            start_nxt     = in_start_pos;
          end
          if (txt_full) begin
            err_txt_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (!seen_r && (pat_len_r != '0) &&
                (CMP_W'(cnt_r) + CMP_W'(1) >= CMP_W'(pat_len_r)) &&
                cand_ok && all_hit) begin
              seen_nxt  = 1'b1;
              first_nxt = CNT_W'(CMP_W'(cnt_r) + CMP_W'(2) - CMP_W'(pat_len_r));
            end
          end
        end
        REQ_END: begin
          pat_len_nxt   = '0;
          cnt_nxt       = '0;
          start_nxt     = '0;
          first_nxt     = '0;
          seen_nxt      = 1'b0;
          err_pat_nxt   = 1'b0;
          err_txt_nxt   = 1'b0;
          txt_phase_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result of the current search
  always_comb begin
    if (err_pat_r) begin
      st = ST_PAT_LONG;
    end else if (err_txt_r) begin
      st = ST_TXT_LONG;
    end else begin
      st = ST_OK;
    end
    res_ok = (st == ST_OK) && (pat_len_r != '0) && (cnt_r != '0) &&
             (start_r != '0) && (CMP_W'(start_r) <= CMP_W'(cnt_r)) &&
             (CMP_W'(pat_len_r) <= CMP_W'(cnt_r)) && seen_r;
    pos_sel = res_ok ? first_r : '0;
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_pos_nxt    = out_pos_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    if (ctl.clr) begin
      out_valid_nxt  = 1'b1;
      out_pos_nxt    = POS_W'(pos_sel);
      out_found_nxt  = (pos_sel != '0);
      out_status_nxt = st;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      cnt_r       <= '0;
      start_r     <= '0;
      first_r     <= '0;
      seen_r      <= 1'b0;
      err_pat_r   <= 1'b0;
      err_txt_r   <= 1'b0;
      txt_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_len_r   <= pat_len_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      first_r     <= first_nxt;
      seen_r      <= seen_nxt;
      err_pat_r   <= err_pat_nxt;
      err_txt_r   <= err_txt_nxt;
      txt_phase_r <= txt_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_pos_r    <= out_pos_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;
  assign out_found          = out_found_r;
  assign out_status         = out_status_r;

  // an accepted end of text always yields a result next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> out_valid_r)
    else $error("end of text without result");

  // a flagged error never reports a match
  a_err_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> !out_found_r)
    else $error("match reported with error status");

  // pattern length stays within the cell row
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length overflow");

  // a recorded match is only dropped by end of text
  a_seen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(seen_r) |-> ($past(ctl.clr) || !$past(rst_n)))
    else $error("match flag lost");

endmodule

>>> rtl/sfms_cell.sv
module sfms_cell import sfms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sfms_ctl_t         ctl,
  input  logic [BYTE_W-1:0] pat_in,
  input  logic              pat_vld_in,
  input  logic [BYTE_W-1:0] txt_in,
  output logic [BYTE_W-1:0] pat_out,
  output logic              pat_vld_out,
  output logic [BYTE_W-1:0] txt_out,
  output logic              hit
);

  logic [BYTE_W-1:0] pat_r;
  logic              pat_vld_r;
  logic [BYTE_W-1:0] txt_r;

  // pattern valid bit, cleared per search
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      pat_vld_r <= 1'b0;
    end else if (ctl.pat_shift) begin
      pat_vld_r <= pat_vld_in;
    end
  end

  // pattern and window bytes
  always_ff @(posedge clk) begin
    if (ctl.pat_shift) begin
      pat_r <= pat_in;
    end
    if (ctl.txt_shift) begin
      txt_r <= txt_in;
    end
  end

  // compare against the byte entering this slot
  assign hit         = !pat_vld_r || (pat_r == txt_in);
  assign pat_out     = pat_r;
  assign pat_vld_out = pat_vld_r;
  assign txt_out     = txt_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sfms_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // expected outcome of one search
  typedef struct {
    logic [POS_W-1:0] pos;
    logic             found;
    status_t          st;
  } search_verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = REQ_NONE;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic [POS_W-1:0]  in_start_pos = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [POS_W-1:0]  out_match_position;
  logic              out_found;
  logic [1:0]        out_status;

  // search predictor state
  logic [7:0]  pat_mem [MAX_PATTERN_DEF];
  logic [7:0]  win [MAX_PATTERN_DEF];
  int unsigned pat_len;
  int unsigned txt_cnt;
  int unsigned start_reg;
  int unsigned hit_pos;
  bit          hit_seen;
  logic [1:0]  err_bits;
  bit          txt_active;

  search_verdict_t verdict_q[$];
  int unsigned     error_count = 0;

  // idling controls
  bit          send_idle_on = 1'b0;
  bit          recv_idle_on = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  substring_first_match_search uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_data_byte       (in_data_byte),
    .in_start_pos       (in_start_pos),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match_position (out_match_position),
    .out_found          (out_found),
    .out_status         (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, what);
  endtask

  // predictor: clear everything but the pattern bytes
  task automatic clear_search();
    int i;
    for (i = 0; i < MAX_PATTERN_DEF; i++) win[i] = '0;
    pat_len = 0;
    txt_cnt = 0;
    start_reg = 0;
    hit_pos = 0;
    hit_seen = 1'b0;
    err_bits = '0;
    txt_active = 1'b0;
  endtask

  // whole pattern against the newest pat_len window bytes
  function automatic bit window_hit();
    int unsigned k;
    for (k = 0; k < pat_len; k++) begin
      if (pat_mem[k] != win[pat_len - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // predictor: one accepted transaction
  task automatic predict_item(input logic [1:0] req, input logic [7:0] d,
                              input logic [15:0] st);
    search_verdict_t v;
    int unsigned cand;
    int i;
    case (req)
      REQ_PATTERN: begin
        if (!txt_active) begin
          if (pat_len < MAX_PATTERN_DEF) begin
            pat_mem[pat_len] = d;
            pat_len++;
          end else begin
            err_bits[0] = 1'b1;
          end
        end
      end
      REQ_TEXT: begin
        if (!txt_active) begin
          txt_active = 1'b1;
          start_reg = 32'(st);
        end
        if (txt_cnt >= MAX_TEXT_DEF) begin
          err_bits[1] = 1'b1;
        end else begin
          for (i = MAX_PATTERN_DEF - 1; i > 0; i--) win[i] = win[i-1];
          win[0] = d;
          txt_cnt++;
          if (!hit_seen && pat_len != 0 && txt_cnt >= pat_len) begin
            cand = txt_cnt - pat_len + 1;
            if (cand >= start_reg && window_hit()) begin
              hit_seen = 1'b1;
              hit_pos = cand;
            end
          end
        end
      end
      REQ_END: begin
        if (err_bits[0]) v.st = ST_PAT_LONG;
        else if (err_bits[1]) v.st = ST_TXT_LONG;
        else v.st = ST_OK;
        v.pos = '0;
        if (v.st == ST_OK && pat_len != 0 && txt_cnt != 0 && start_reg >= 1 &&
            start_reg <= txt_cnt && pat_len <= txt_cnt && hit_seen)
          v.pos = hit_pos[POS_W-1:0];
        v.found = (v.pos != 0);
        verdict_q.push_back(v);
        clear_search();
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!send_idle_on || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // drive one transaction and wait until it is taken
  task automatic send_item(input logic [1:0] req, input logic [7:0] d,
                           input logic [15:0] st);
    int unsigned gap;
    bit taken;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_data_byte <= d;
    in_start_pos <= st;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_item(req, d, st);
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // pattern, text, end; start rides on the first text byte only
  task automatic send_search(input byte_q_t pat, input byte_q_t txt,
                             input logic [15:0] st, input bit noisy);
    int i;
    for (i = 0; i < pat.size(); i++) begin
      if (noisy && $urandom_range(0, 99) < 4)
        send_item(REQ_NONE, 8'($urandom), 16'($urandom));
      send_item(REQ_PATTERN, pat[i], 16'($urandom));
    end
    for (i = 0; i < txt.size(); i++) begin
      send_item(REQ_TEXT, txt[i], (i == 0) ? st : 16'($urandom));
      if (noisy && $urandom_range(0, 99) < 5)
        send_item(REQ_PATTERN, 8'($urandom), 16'($urandom));
      if (noisy && $urandom_range(0, 99) < 3)
        send_item(REQ_NONE, 8'($urandom), 16'($urandom));
    end
    send_item(REQ_END, 8'($urandom), 16'($urandom));
  endtask

  // result checker, sampled mid-cycle
  always @(negedge clk) begin
    search_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("result pos=%0d with no search pending",
                             out_match_position));
      end else begin
        want = verdict_q.pop_front();
        if (out_match_position !== want.pos)
          flag_error($sformatf("match_position %0d, want %0d",
                               out_match_position, want.pos));
        if (out_found !== want.found)
          flag_error($sformatf("found %0b, want %0b", out_found, want.found));
        if (out_status !== want.st)
          flag_error($sformatf("status %0d, want %0d", out_status, want.st));
      end
    end
  end

  // result side backpressure, with long holds on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (recv_idle_on && $urandom_range(0, 99) < 15) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                : $urandom_range(3, 25);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_plain_match();
    send_search(to_bytes("ab"), to_bytes("xxabab"), 16'd1, 1'b0);
    send_search(to_bytes("abc"), to_bytes("abc"), 16'd1, 1'b0);
    send_search(to_bytes("a"), to_bytes("bbbb"), 16'd1, 1'b0);
  endtask

  task automatic test_degenerate();
    // empty pattern, empty text, start zero
    send_search(to_bytes(""), to_bytes("abc"), 16'd1, 1'b0);
    send_search(to_bytes("ab"), to_bytes(""), 16'd1, 1'b0);
    send_search(to_bytes("ab"), to_bytes("ab"), 16'd0, 1'b0);
    // start past the text, start on the last byte
    send_search(to_bytes("a"), to_bytes("aaa"), 16'd4, 1'b0);
    send_search(to_bytes("b"), to_bytes("aab"), 16'd3, 1'b0);
    // pattern longer than text
    send_search(to_bytes("abcd"), to_bytes("abc"), 16'd1, 1'b0);
  endtask

  task automatic test_start_skip();
    send_search(to_bytes("ab"), to_bytes("ababab"), 16'd2, 1'b0);
    send_search(to_bytes("ab"), to_bytes("ababab"), 16'd6, 1'b0);
  endtask

  task automatic test_byte_extremes();
    byte_q_t pat, txt;
    pat = '{8'h00, 8'hFF};
    txt = '{8'hFF, 8'h00, 8'hFF, 8'hFF};
    send_search(pat, txt, 16'd1, 1'b0);
    send_search(pat, txt, 16'hFFFF, 1'b0);
    send_search(pat, txt, 16'h5555, 1'b0);
  endtask

  task automatic test_pattern_size();
    byte_q_t pat, txt;
    int i;
    for (i = 0; i < MAX_PATTERN_DEF; i++) pat.push_back(8'($urandom));
    for (i = 0; i < 4; i++) txt.push_back(8'hC3);
    for (i = 0; i < MAX_PATTERN_DEF; i++) txt.push_back(pat[i]);
    // full store, match at position 5
    send_search(pat, txt, 16'd1, 1'b0);
    // one byte past the store
    pat.push_back(8'h11);
    send_search(pat, txt, 16'd1, 1'b0);
  endtask

  task automatic test_ignored_requests();
    // late pattern byte and unused request inside a search
    send_item(REQ_NONE, 8'h61, 16'd9);
    send_item(REQ_PATTERN, 8'h61, 16'd0);
    send_item(REQ_PATTERN, 8'h62, 16'd0);
    send_item(REQ_TEXT, 8'h61, 16'd1);
    send_item(REQ_PATTERN, 8'h63, 16'd0);
    send_item(REQ_NONE, 8'h63, 16'd0);
    send_item(REQ_TEXT, 8'h62, 16'd7);
    send_item(REQ_END, 8'hA5, 16'hFFFF);
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    hold_req = 400;
    for (i = 0; i < 5; i++)
      send_search(to_bytes("cd"), to_bytes("abcdcd"), 16'(i + 1), 1'b0);
  endtask

  task automatic random_search(output int unsigned fed);
    byte_q_t pat, txt;
    logic [7:0] sym [4];
    int unsigned plen, tlen, nsym, r, at, i;
    logic [15:0] st;
    for (i = 0; i < 4; i++) sym[i] = 8'($urandom);
    // a small alphabet makes partial and repeated matches common
    nsym = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
    r = $urandom_range(0, 99);
    if (r < 4) plen = 0;
    else if (r < 10) plen = $urandom_range(9, 32);
    else if (r < 13) plen = $urandom_range(33, 40);
    else plen = $urandom_range(1, 5);
    r = $urandom_range(0, 99);
    if (r < 4) tlen = 0;
    else if (r < 90) tlen = $urandom_range(1, 40);
    else tlen = $urandom_range(41, 120);
    for (i = 0; i < plen; i++)
      pat.push_back((nsym == 0) ? 8'($urandom) : sym[$urandom_range(0, nsym - 1)]);
    for (i = 0; i < tlen; i++)
      txt.push_back((nsym == 0) ? 8'($urandom) : sym[$urandom_range(0, nsym - 1)]);
    // plant the pattern somewhere half the time
    if (plen != 0 && plen <= MAX_PATTERN_DEF && plen <= tlen && $urandom_range(0, 1)) begin
      at = $urandom_range(0, tlen - plen);
      for (i = 0; i < plen; i++) txt[at + i] = pat[i];
    end
    r = $urandom_range(0, 99);
    if (r < 70) st = 16'($urandom_range(1, (tlen == 0) ? 1 : tlen));
    else if (r < 78) st = '0;
    else if (r < 86) st = 16'(tlen + $urandom_range(1, 3));
    else st = 16'($urandom);
    send_search(pat, txt, st, 1'b1);
    fed = plen + tlen + 1;
  endtask

  task automatic test_random();
    int unsigned total, fed, n, r;
    total = 0;
    n = 0;
    while (total < 1500) begin
      // change idling pattern every few searches
      if (n % 8 == 0) begin
        r = $urandom_range(0, 3);
        send_idle_on = (r == 0 || r == 1);
        recv_idle_on = (r == 0 || r == 2);
      end
      random_search(fed);
      total += fed;
      n++;
    end
  endtask

  initial begin
    int unsigned w;
    clear_search();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_match();
    test_degenerate();
    test_start_skip();
    test_byte_extremes();
    test_pattern_size();
    test_ignored_requests();
    test_backpressure();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_random();

    // drain
    in_valid <= 1'b0;
    recv_idle_on = 1'b0;
    for (w = 0; w < 5000 && verdict_q.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (verdict_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", verdict_q.size()));

    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
